/* rtl/pibd_pkg.sv */
package pibd_pkg;

  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned HuntLimit     = 10;
  localparam int unsigned HuntKeep      = 6;
  localparam int unsigned MaxResults    = 17;
  localparam int unsigned NresWidth     = 5;
  localparam int unsigned InQDepth      = 2;
  localparam int unsigned ResQDepth     = 4;

  localparam logic [1:0] KIND_BIT   = 2'd0;
  localparam logic [1:0] KIND_SYNC  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] REG_HALF_LO = 2'd0;
  localparam logic [1:0] REG_HALF_HI = 2'd1;
  localparam logic [1:0] REG_FULL_LO = 2'd2;
  localparam logic [1:0] REG_FULL_HI = 2'd3;

  localparam logic [IntervalWidth-1:0] HALF_LO_RST = 16'd40;
  localparam logic [IntervalWidth-1:0] HALF_HI_RST = 16'd60;
  localparam logic [IntervalWidth-1:0] FULL_LO_RST = 16'd80;
  localparam logic [IntervalWidth-1:0] FULL_HI_RST = 16'd120;

  typedef struct packed {
    logic [IntervalWidth-1:0] half_lo;
    logic [IntervalWidth-1:0] half_hi;
    logic [IntervalWidth-1:0] full_lo;
    logic [IntervalWidth-1:0] full_hi;
  } cfg_t;

  typedef struct packed {
    logic is_long;
    logic is_short;
  } cls_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       bit_value;
    logic       last;
  } res_t;

  function automatic cls_t classify(logic [IntervalWidth-1:0] v, cfg_t c);
    cls_t r;
    r.is_short = (v >= c.half_lo) && (v <= c.half_hi);
    r.is_long  = (v >= c.full_lo) && (v <= c.full_hi);
    return r;
  endfunction

endpackage

/* rtl/pibd_fifo.sv */
module pibd_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/pibd_back.sv */
module pibd_back import pibd_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  input  logic [IntervalWidth-1:0] in_data_i,
  output logic                     in_pop_o,
  input  logic                     res_full_i,
  output logic                     res_push_o,
  output res_t                     res_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW:0]   DepthX  = (CW+1)'(BUFFER_DEPTH);
  localparam logic [CW-1:0] DepthC  = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] HuntLim = CW'(HuntLimit);
  localparam logic [CW-1:0] HuntKp  = CW'(HuntKeep);
  localparam logic [NresWidth-1:0] MaxRes = NresWidth'(MaxResults);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [IntervalWidth-1:0] mem_q [BUFFER_DEPTH];
  logic [IntervalWidth-1:0] rdata_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;

  logic [1:0]           state_q, state_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 in_sync_q, in_sync_d;
  logic                 found_q, found_d;
  logic [CW-1:0]        pos_q, pos_d;
  cls_t                 cls_q [3];
  cls_t                 cls_d [3];
  cls_t                 win_q [3];
  cls_t                 win_d [3];
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic [CW-1:0]        lim_q, lim_d;
  logic                 full_scan_q, full_scan_d;
  logic                 rvld_q, rvld_d;
  logic [CW-1:0]        rcv_idx_q, rcv_idx_d;
  logic [NresWidth-1:0] nres_q, nres_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [1:0]           pend_kind_q, pend_kind_d;
  logic                 pend_bit_q, pend_bit_d;

  function automatic logic [AW-1:0] ptr_add(logic [AW-1:0] p, logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(p) + {1'b0, k};
    if (s >= DepthX) begin
      s = s - DepthX;
    end
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_data_i;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign mem_raddr = ptr_add(head_q, rd_idx_q);

  always_comb begin
    cls_t          c;
    logic          match;
    logic          issue;
    logic          dec_ret, emit, hunt_drop, rescan, set_sync, clr_sync, stall;
    logic [1:0]    ekind;
    logic          ebit;
    logic [CW-1:0] drop_k, cnt_n;
    logic          s0, s1, l0, l1, l2, wait_more;
    logic [CW:0]   pos_x4, cnt_x;

    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    in_sync_d    = in_sync_q;
    found_d      = found_q;
    pos_d        = pos_q;
    cls_d        = cls_q;
    win_d        = win_q;
    rd_idx_d     = rd_idx_q;
    lim_d        = lim_q;
    full_scan_d  = full_scan_q;
    rvld_d       = 1'b0;
    rcv_idx_d    = rcv_idx_q;
    nres_d       = nres_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_bit_d   = pend_bit_q;
    mem_we       = 1'b0;
    mem_waddr    = ptr_add(head_q, count_q);
    in_pop_o     = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '{kind: pend_kind_q, bit_value: pend_bit_q, last: 1'b0};

    c         = classify(rdata_q, cfg_i);
    match     = 1'b0;
    issue     = 1'b0;
    dec_ret   = 1'b0;
    emit      = 1'b0;
    hunt_drop = 1'b0;
    rescan    = 1'b0;
    set_sync  = 1'b0;
    clr_sync  = 1'b0;
    stall     = 1'b0;
    ekind     = KIND_BIT;
    ebit      = 1'b0;
    drop_k    = '0;
    cnt_n     = count_q;
    s0        = cls_q[0].is_short;
    s1        = cls_q[1].is_short;
    l0        = cls_q[0].is_long;
    l1        = cls_q[1].is_long;
    l2        = cls_q[2].is_long;
    pos_x4    = {1'b0, pos_q} + (CW+1)'(4);
    cnt_x     = {1'b0, count_q};
    wait_more = (l0 && (count_q >= CW'(2)) && s1 &&
                 ((count_q < CW'(3)) || (l2 && (count_q < CW'(5))))) ||
                (!l0 && s0 && (count_q >= CW'(2)) && l1 &&
                 ((count_q < CW'(3)) || (l2 && (count_q < CW'(4)))));

    unique case (state_q)
      ST_IDLE: begin
        nres_d = '0;
        if (in_valid_i) begin
          in_pop_o = 1'b1;
          mem_we   = 1'b1;
          if (count_q == DepthC) begin
            mem_waddr = head_q;
            head_d    = ptr_add(head_q, CW'(1));
            if (in_sync_q) begin
              pend_valid_d = 1'b1;
              pend_kind_d  = KIND_ERROR;
              pend_bit_d   = 1'b0;
              nres_d       = NresWidth'(1);
              in_sync_d    = 1'b0;
            end
            lim_d = count_q;
          end else begin
            count_d = count_q + 1'b1;
            lim_d   = count_q + 1'b1;
          end
          rd_idx_d    = '0;
          full_scan_d = 1'b1;
          found_d     = 1'b0;
          state_d     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (rvld_q) begin
          if (rcv_idx_q < CW'(3)) begin
            cls_d[rcv_idx_q[1:0]] = c;
          end
          if (full_scan_q) begin
            match = (rcv_idx_q >= CW'(3)) && win_q[0].is_short && win_q[1].is_long &&
                    win_q[2].is_long && c.is_short;
            win_d[0] = win_q[1];
            win_d[1] = win_q[2];
            win_d[2] = c;
          end
        end
        if (match) begin
          found_d = 1'b1;
          pos_d   = rcv_idx_q - CW'(3);
        end
        issue = !match && (rd_idx_q < lim_q);
        if (issue) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          rvld_d    = 1'b1;
          rcv_idx_d = rd_idx_q;
        end else begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (found_q && (pos_x4 >= cnt_x)) begin
          dec_ret = 1'b1;
        end else if (found_q && (pos_q > CW'(1)) && !in_sync_q) begin
          drop_k    = pos_q - CW'(1);
          hunt_drop = 1'b1;
        end else if (found_q && (pos_q <= CW'(1))) begin
          emit     = 1'b1;
          ekind    = KIND_SYNC;
          set_sync = 1'b1;
          drop_k   = pos_q + CW'(5);
          rescan   = 1'b1;
        end else if (count_q == '0) begin
          dec_ret = 1'b1;
        end else if (!in_sync_q) begin
          dec_ret = 1'b1;
          if (count_q > HuntLim) begin
            drop_k = count_q - HuntKp;
          end
        end else if (!found_q && wait_more) begin
          dec_ret = 1'b1;
        end else if (l0) begin
          if (count_q < CW'(2)) begin
            dec_ret = 1'b1;
          end else begin
            emit   = 1'b1;
            drop_k = CW'(1);
          end
        end else if (s0) begin
          if (count_q < CW'(2)) begin
            dec_ret = 1'b1;
          end else if (s1) begin
            emit   = 1'b1;
            ebit   = 1'b1;
            drop_k = CW'(2);
          end else begin
            emit     = 1'b1;
            ekind    = KIND_ERROR;
            drop_k   = CW'(1);
            clr_sync = 1'b1;
          end
        end else begin
          emit     = 1'b1;
          ekind    = KIND_ERROR;
          drop_k   = CW'(1);
          clr_sync = 1'b1;
        end

        stall = emit && (nres_q < MaxRes) && pend_valid_q && res_full_i;
        cnt_n = count_q - drop_k;
        if (!stall) begin
          head_d  = ptr_add(head_q, drop_k);
          count_d = cnt_n;
          if (emit && (nres_q < MaxRes)) begin
            res_push_o   = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_kind_d  = ekind;
            pend_bit_d   = ebit;
            nres_d       = nres_q + 1'b1;
          end
          if (set_sync) begin
            in_sync_d = 1'b1;
          end else if (clr_sync) begin
            in_sync_d = 1'b0;
          end
          if (rescan) begin
            found_d = 1'b0;
          end else if (found_q) begin
            pos_d = hunt_drop ? CW'(1) : pos_q - drop_k;
          end
          if (dec_ret) begin
            state_d = ST_FINISH;
          end else begin
            state_d     = ST_SCAN;
            rd_idx_d    = '0;
            full_scan_d = rescan;
            lim_d       = (rescan || (cnt_n < CW'(3))) ? cnt_n : CW'(3);
          end
        end
      end

      ST_FINISH: begin
        res_o.last = 1'b1;
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      in_sync_q    <= 1'b0;
      found_q      <= 1'b0;
      pos_q        <= '0;
      rd_idx_q     <= '0;
      lim_q        <= '0;
      full_scan_q  <= 1'b0;
      rvld_q       <= 1'b0;
      rcv_idx_q    <= '0;
      nres_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      in_sync_q    <= in_sync_d;
      found_q      <= found_d;
      pos_q        <= pos_d;
      rd_idx_q     <= rd_idx_d;
      lim_q        <= lim_d;
      full_scan_q  <= full_scan_d;
      rvld_q       <= rvld_d;
      rcv_idx_q    <= rcv_idx_d;
      nres_q       <= nres_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q       <= cls_d;
    win_q       <= win_d;
    pend_kind_q <= pend_kind_d;
    pend_bit_q  <= pend_bit_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthC)
    else $error("interval count above buffer depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> ({1'b0, pos_q} + (CW+1)'(4) <= {1'b0, count_q}))
    else $error("sync position beyond stored intervals");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending result left over between transactions");

  assert property (@(posedge clk_i) disable iff (!rst_ni) nres_q <= MaxRes)
    else $error("too many results for one interval");

endmodule

/* rtl/pulse_interval_bit_decoder_unit.sv */
// Biphase-mark interval decoder. Each input transaction carries one edge-to-edge
// interval; it is queued, appended to an interval buffer of BUFFER_DEPTH entries, and
// the buffer is decoded into result transactions (bit, sync found, error), the last
// result of each interval flagged by last_o. The buffer is scanned in full for each new
// interval and again after each sync found, and the head entries are read again before
// every other decode step; the buffer memory has a single read port and is read one
// entry per cycle. A two-deep input queue and a four-deep result queue decouple both
// sides; the decoder waits while the result queue is full. The user must write the
// window registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; the block
// does not enforce it.
module pulse_interval_bit_decoder_unit import pibd_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [IntervalWidth-1:0] cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  logic [IntervalWidth-1:0] interval_us_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               event_kind_o,
  output logic                     bit_value_o,
  output logic                     last_o
);

  cfg_t                     cfg_q;
  logic                     in_empty, in_pop;
  logic [IntervalWidth-1:0] in_data;
  logic                     res_full, res_push;
  res_t                     res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_lo <= HALF_LO_RST;
      cfg_q.half_hi <= HALF_HI_RST;
      cfg_q.full_lo <= FULL_LO_RST;
      cfg_q.full_hi <= FULL_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_LO: cfg_q.half_lo <= cfg_wdata_i;
        REG_HALF_HI: cfg_q.half_hi <= cfg_wdata_i;
        REG_FULL_LO: cfg_q.full_lo <= cfg_wdata_i;
        REG_FULL_HI: cfg_q.full_hi <= cfg_wdata_i;
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  pibd_fifo #(
    .WIDTH(IntervalWidth),
    .DEPTH(InQDepth)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (interval_us_i),
    .full_o (full),
    .pop_i  (in_pop),
    .data_o (in_data),
    .empty_o(in_empty)
  );

  pibd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(!in_empty),
    .in_data_i (in_data),
    .in_pop_o  (in_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_in)
  );

  pibd_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(ResQDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign event_kind_o = res_out.kind;
  assign bit_value_o  = res_out.bit_value;
  assign last_o       = res_out.last;

endmodule
